// ===== rtl/core/tafbu_pkg.sv =====
// ----------------------------------------------------------------------------
// tafbu_pkg
// Shared types and instruction codes for the thumb alu, flags and branch unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tafbu_pkg;

    localparam int unsigned MODE_W = 6;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned SHIFT_W = 5;
    localparam int unsigned OFFSET_W = 22;

    typedef logic [MODE_W-1:0] t_mode;
    typedef logic [DATA_W-1:0] t_word;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } t_flags;

    localparam t_mode MODE_ADC = 6'd0;
    localparam t_mode MODE_ADD = 6'd1;
    localparam t_mode MODE_EOR = 6'd2;
    localparam t_mode MODE_ORR = 6'd3;
    localparam t_mode MODE_AND = 6'd4;
    localparam t_mode MODE_MOV = 6'd5;
    localparam t_mode MODE_SUB = 6'd6;
    localparam t_mode MODE_CMP = 6'd7;
    localparam t_mode MODE_CMN = 6'd8;
    localparam t_mode MODE_MUL = 6'd9;
    localparam t_mode MODE_TST = 6'd10;
    localparam t_mode MODE_LSL = 6'd11;
    localparam t_mode MODE_LSR = 6'd12;
    localparam t_mode MODE_ROR = 6'd13;
    localparam t_mode MODE_ASR = 6'd14;
    localparam t_mode MODE_REV = 6'd15;
    localparam t_mode MODE_BIC = 6'd16;
    localparam t_mode MODE_MVN = 6'd17;
    localparam t_mode MODE_NOP = 6'd18;
    localparam t_mode MODE_NEG = 6'd19;
    localparam t_mode MODE_SBC = 6'd20;
    localparam t_mode MODE_BEQ = 6'd21;
    localparam t_mode MODE_BNE = 6'd22;
    localparam t_mode MODE_BCS = 6'd23;
    localparam t_mode MODE_BCC = 6'd24;
    localparam t_mode MODE_BMI = 6'd25;
    localparam t_mode MODE_BPL = 6'd26;
    localparam t_mode MODE_BVS = 6'd27;
    localparam t_mode MODE_BVC = 6'd28;
    localparam t_mode MODE_BHI = 6'd29;
    localparam t_mode MODE_BLS = 6'd30;
    localparam t_mode MODE_BGE = 6'd31;
    localparam t_mode MODE_BLT = 6'd32;
    localparam t_mode MODE_BGT = 6'd33;
    localparam t_mode MODE_BLE = 6'd34;
    localparam t_mode MODE_B   = 6'd35;
    localparam t_mode MODE_BL  = 6'd36;
    localparam t_mode MODE_BX  = 6'd37;

    localparam t_word PC_STEP = 32'd2;

endpackage

`default_nettype wire

// ===== rtl/core/tafbu_exec.sv =====
// ----------------------------------------------------------------------------
// tafbu_exec
// Execute logic: alu result, next flags, next pc and link register.
// ----------------------------------------------------------------------------
`default_nettype none

module tafbu_exec
    import tafbu_pkg::*;
(
    input  wire t_mode                       i_mode,
    input  wire t_word                       i_operand_a,
    input  wire t_word                       i_operand_b,
    input  wire logic [SHIFT_W-1:0]          i_shift_amount,
    input  wire logic signed [OFFSET_W-1:0]  i_branch_offset,
    input  wire t_flags                      i_flags,
    input  wire t_word                       i_pc,
    input  wire t_word                       i_lr,
    output t_word                            o_result,
    output logic                             o_writes_result,
    output t_flags                           o_flags,
    output t_word                            o_pc,
    output t_word                            o_lr
);

    t_word                  add_x;
    t_word                  add_y;
    logic                   add_cin;
    logic [DATA_W:0]        add_sum;
    logic                   add_v;
    t_word                  mul_res;
    logic [DATA_W:0]        lsl_ext;
    logic [DATA_W:0]        lsr_ext;
    logic [DATA_W:0]        asr_ext;
    logic [2*DATA_W-1:0]    ror_ext;
    t_word                  jump;
    t_word                  pc_seq;
    t_word                  pc_jump;
    logic                   sh_nz;
    logic                   taken;
    t_word                  r;
    logic                   writes;
    logic                   set_nz;

    assign mul_res = i_operand_a * i_operand_b;
    assign sh_nz = (i_shift_amount != '0);
    assign lsl_ext = {1'b0, i_operand_a} << i_shift_amount;
    assign lsr_ext = {i_operand_a, 1'b0} >> i_shift_amount;
    assign asr_ext = $signed({i_operand_a, 1'b0}) >>> i_shift_amount;
    assign ror_ext = {i_operand_a, i_operand_a} >> i_shift_amount;
    assign jump = {{(DATA_W-OFFSET_W-1){i_branch_offset[OFFSET_W-1]}}, i_branch_offset, 1'b0};
    assign pc_seq = i_pc + PC_STEP;
    assign pc_jump = i_pc + jump;

    // adder operand select
    always_comb begin
        add_x = i_operand_a;
        add_y = i_operand_b;
        add_cin = 1'b0;
        case (i_mode)
            MODE_ADC: begin
                add_cin = i_flags.c;
            end
            MODE_SUB, MODE_CMP: begin
                add_y = ~i_operand_b;
                add_cin = 1'b1;
            end
            MODE_SBC: begin
                add_y = ~i_operand_b;
                add_cin = i_flags.c;
            end
            MODE_NEG: begin
                add_x = '0;
                add_y = ~i_operand_a;
                add_cin = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{DATA_W{1'b0}}, add_cin};
    assign add_v = ~(add_x[DATA_W-1] ^ add_y[DATA_W-1]) &
                   (add_x[DATA_W-1] ^ add_sum[DATA_W-1]);

    always_comb begin
        r = '0;
        writes = 1'b0;
        set_nz = 1'b0;
        o_flags = i_flags;
        o_pc = pc_seq;
        o_lr = i_lr;
        taken = 1'b0;
        unique case (i_mode) inside
            MODE_ADC, MODE_ADD, MODE_SUB, MODE_SBC, MODE_NEG: begin
                r = add_sum[DATA_W-1:0];
                writes = 1'b1;
                set_nz = 1'b1;
                o_flags.c = add_sum[DATA_W];
                o_flags.v = add_v;
            end
            MODE_CMP, MODE_CMN: begin
                r = add_sum[DATA_W-1:0];
                set_nz = 1'b1;
                o_flags.c = add_sum[DATA_W];
                o_flags.v = add_v;
            end
            MODE_EOR: begin
                r = i_operand_a ^ i_operand_b;
                writes = 1'b1;
                set_nz = 1'b1;
            end
            MODE_ORR: begin
                r = i_operand_a | i_operand_b;
                writes = 1'b1;
                set_nz = 1'b1;
            end
            MODE_AND: begin
                r = i_operand_a & i_operand_b;
                writes = 1'b1;
                set_nz = 1'b1;
            end
            MODE_TST: begin
                r = i_operand_a & i_operand_b;
                set_nz = 1'b1;
            end
            MODE_MOV: begin
                r = i_operand_a;
                writes = 1'b1;
                set_nz = 1'b1;
            end
            MODE_MUL: begin
                r = mul_res;
                writes = 1'b1;
                set_nz = 1'b1;
            end
            MODE_LSL: begin
                r = lsl_ext[DATA_W-1:0];
                writes = 1'b1;
                set_nz = 1'b1;
                if (sh_nz) begin
                    o_flags.c = lsl_ext[DATA_W];
                end
            end
            MODE_LSR: begin
                r = lsr_ext[DATA_W:1];
                writes = 1'b1;
                set_nz = 1'b1;
                if (sh_nz) begin
                    o_flags.c = lsr_ext[0];
                end
            end
            MODE_ASR: begin
                r = asr_ext[DATA_W:1];
                writes = 1'b1;
                set_nz = 1'b1;
                if (sh_nz) begin
                    o_flags.c = asr_ext[0];
                end
            end
            MODE_ROR: begin
                r = ror_ext[DATA_W-1:0];
                writes = 1'b1;
                set_nz = 1'b1;
                if (sh_nz) begin
                    o_flags.c = ror_ext[DATA_W-1];
                end
            end
            MODE_REV: begin
                r = {i_operand_a[7:0], i_operand_a[15:8], i_operand_a[23:16],
                     i_operand_a[31:24]};
                writes = 1'b1;
            end
            MODE_BIC: begin
                r = i_operand_a & ~i_operand_b;
                writes = 1'b1;
                set_nz = 1'b1;
            end
            MODE_MVN: begin
                r = ~i_operand_a;
                writes = 1'b1;
                set_nz = 1'b1;
            end
            MODE_BEQ: taken = i_flags.z;
            MODE_BNE: taken = ~i_flags.z;
            MODE_BCS: taken = i_flags.c;
            MODE_BCC: taken = ~i_flags.c;
            MODE_BMI: taken = i_flags.n;
            MODE_BPL: taken = ~i_flags.n;
            MODE_BVS: taken = i_flags.v;
            MODE_BVC: taken = ~i_flags.v;
            MODE_BHI: taken = i_flags.c & ~i_flags.z;
            MODE_BLS: taken = ~i_flags.c | i_flags.z;
            MODE_BGE: taken = (i_flags.n == i_flags.v);
            MODE_BLT: taken = (i_flags.n != i_flags.v);
            MODE_BGT: taken = ~i_flags.z & (i_flags.n == i_flags.v);
            MODE_BLE: taken = i_flags.z | (i_flags.n != i_flags.v);
            MODE_B: taken = 1'b1;
            MODE_BL: begin
                taken = 1'b1;
                o_lr = pc_seq;
            end
            MODE_BX: o_pc = i_operand_a;
            default: begin
            end
        endcase
        if (taken) begin
            o_pc = pc_jump;
        end
        if (set_nz) begin
            o_flags.n = r[DATA_W-1];
            o_flags.z = (r == '0);
        end
        o_writes_result = writes;
        o_result = writes ? r : '0;
    end

endmodule

`default_nettype wire

// ===== rtl/core/thumb_alu_flags_branch_unit_core.sv =====
// ----------------------------------------------------------------------------
// thumb_alu_flags_branch_unit_core
// Each beat is held in the input register, then in the result register.
// One beat per cycle unless stalled; flags, pc and link feed the next beat directly.
// Reset clears flags, pc, link register and both valid bits; payload is not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module thumb_alu_flags_branch_unit_core
    import tafbu_pkg::*;
(
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire t_mode                   i_mode,
    input  wire t_word                   i_operand_a,
    input  wire t_word                   i_operand_b,
    input  wire [SHIFT_W-1:0]            i_shift_amount,
    input  wire signed [OFFSET_W-1:0]    i_branch_offset,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output t_word                        o_result,
    output logic                         o_writes_result,
    output logic                         o_negative_out,
    output logic                         o_zero_out,
    output logic                         o_carry_out,
    output logic                         o_overflow_out,
    output t_word                        o_next_pc,
    output t_word                        o_link_value
);

    logic                          r_in_valid;
    t_mode                         r_mode;
    t_word                         r_operand_a;
    t_word                         r_operand_b;
    logic [SHIFT_W-1:0]            r_shift_amount;
    logic signed [OFFSET_W-1:0]    r_branch_offset;

    logic                          r_out_valid;
    t_word                         r_result;
    logic                          r_writes_result;

    t_flags                        r_flags;
    t_word                         r_pc;
    t_word                         r_lr;

    t_word                         n_result;
    logic                          n_writes_result;
    t_flags                        n_flags;
    t_word                         n_pc;
    t_word                         n_lr;

    logic                          out_free;
    logic                          exec_move;
    logic                          in_take;

    assign out_free = ~r_out_valid | ~i_out_stall;
    assign exec_move = r_in_valid & out_free;
    assign o_in_stall = r_in_valid & ~out_free;
    assign in_take = i_in_valid & ~o_in_stall;

    tafbu_exec u_exec (
        .i_mode          (r_mode),
        .i_operand_a     (r_operand_a),
        .i_operand_b     (r_operand_b),
        .i_shift_amount  (r_shift_amount),
        .i_branch_offset (r_branch_offset),
        .i_flags         (r_flags),
        .i_pc            (r_pc),
        .i_lr            (r_lr),
        .o_result        (n_result),
        .o_writes_result (n_writes_result),
        .o_flags         (n_flags),
        .o_pc            (n_pc),
        .o_lr            (n_lr)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (in_take) begin
            r_mode <= i_mode;
            r_operand_a <= i_operand_a;
            r_operand_b <= i_operand_b;
            r_shift_amount <= i_shift_amount;
            r_branch_offset <= i_branch_offset;
        end
    end

    // architectural state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_flags <= '0;
            r_pc <= '0;
            r_lr <= '0;
        end else begin
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (exec_move) begin
                r_flags <= n_flags;
                r_pc <= n_pc;
                r_lr <= n_lr;
            end
        end
        if (exec_move) begin
            r_result <= n_result;
            r_writes_result <= n_writes_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result = r_result;
    assign o_writes_result = r_writes_result;
    assign o_negative_out = r_flags.n;
    assign o_zero_out = r_flags.z;
    assign o_carry_out = r_flags.c;
    assign o_overflow_out = r_flags.v;
    assign o_next_pc = r_pc;
    assign o_link_value = r_lr;

endmodule

`default_nettype wire
